>>> hw/rtl/lsb_pkg.sv
// shared types and constants of the lottery scheduler
package lsb_pkg;

	localparam int SLOTS = 64;
	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW    = 17 + IW + 1;

	localparam logic [1:0] OP_DRAW = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;
	localparam logic [1:0] OP_LOAD = 2'd3;

	localparam logic [1:0] RS_RUNNABLE = 2'd1;
	localparam logic [1:0] RS_SLEEPING = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_ZERO = 2'd2;

	localparam logic [15:0] BOOST_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] random_value;
		logic [22:0] draw_total;
		logic [5:0]  slot_index;
		logic [14:0] pid_in;
		logic [15:0] ticket_count;
		logic [1:0]  run_state_in;
		logic [31:0] sleep_ticks;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  winner_slot;
		logic [14:0] winner_pid;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  run_state;
		logic [14:0] pid;
		logic [15:0] base_share;
		logic [16:0] effective_share;
		logic [15:0] boost_left;
		logic [31:0] sleep_begin;
		logic [31:0] sleep_length;
	} slot_rec_t;

endpackage

>>> hw/rtl/lsb_cell.sv
// one slot cell of the rotating slot ring
module lsb_cell import lsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  slot_rec_t d,
	output slot_rec_t q
);

	slot_rec_t rec_q;

	// takes the neighbour's record on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

>>> hw/rtl/lsb_mod.sv
// restoring remainder unit, one dividend bit per cycle
module lsb_mod import lsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [22:0] divisor,
	output logic        done,
	output logic [22:0] rem
);

	logic [31:0] num_q;
	logic [22:0] den_q;
	logic [23:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [23:0] trial;

	assign trial = {rem_q[22:0], num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rem = rem_q[22:0];

endmodule

>>> hw/rtl/lottery_scheduler_with_boost.sv
// top level of the lottery scheduler with sleep boost
//
// request channel req/req_valid/req_stall carries one beat per command:
// draw, timer tick, set tickets by pid, or load slot. response channel
// rsp/rsp_valid/rsp_stall returns exactly one beat per request.
// the slot table lives in a ring of SLOTS cells that rotates one place a
// cycle while a command scans it; the record at the head cell is examined and
// rewritten by the head logic and goes back in at the tail, so after SLOTS
// shifts the ring is back in order.
// a draw runs the remainder unit first and then one full rotation of the
// ring; tick, set tickets and load only rotate the ring. every command then
// passes the holding state, which loads the response register. a draw with
// a zero ticket total skips both the remainder unit and the rotation and
// goes straight to the holding state. the next request is taken once the
// command has left the holding state.
// req_stall is high while a command is in progress; a finished response
// waits in a holding register, so a new request is taken while the previous
// response is still stalled, and its result waits until the beat goes out.
// reset clears every slot, the tick counter and all handshake state.
module lottery_scheduler_with_boost import lsb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0]    state_q;
	req_t          req_q;
	logic [IW-1:0] cnt_q;
	logic [SW-1:0] sum_q;
	logic [22:0]   win_q;
	logic          found_q;
	logic [5:0]    hit_slot_q;
	logic [14:0]   hit_pid_q;
	logic          zero_q;
	logic [31:0]   tick_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          accept;
	logic          rsp_free;
	logic          shift;
	logic          div_start;
	logic          div_done;
	logic [22:0]   div_rem;

	slot_rec_t     ring [SLOTS];
	slot_rec_t     head;
	slot_rec_t     head_nxt;
	logic          hit;
	logic [SW-1:0] sum_nxt;
	logic [5:0]    cnt_slot;
	logic [IW+5:0] cnt_ext;
	rsp_t          res;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign shift     = (state_q == S_SCAN);
	assign div_start = accept && (req.opcode == OP_DRAW) && (req.draw_total != '0);

	lsb_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.random_value),
		.divisor  (req.draw_total),
		.done     (div_done),
		.rem      (div_rem)
	);

	// the ring: each cell takes its right neighbour, the tail takes the head result
	for (genvar i = 0; i < SLOTS; i++) begin : g_ring
		if (i == SLOTS - 1) begin : g_tail
			lsb_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.d(head_nxt), .q(ring[i]));
		end else begin : g_mid
			lsb_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.d(ring[i+1]), .q(ring[i]));
		end
	end

	assign head     = ring[0];
	assign cnt_ext  = (IW + 6)'(cnt_q);
	assign cnt_slot = cnt_ext[5:0];

	// head logic: one slot per cycle, slot number is cnt_q
	always_comb begin
		logic [15:0] boost;
		logic [31:0] elapsed;
		head_nxt = head;
		hit      = 1'b0;
		sum_nxt  = sum_q;
		boost    = head.boost_left;
		elapsed  = tick_q - head.sleep_begin;
		unique case (req_q.opcode)
			OP_DRAW: begin
				if (head.run_state == RS_RUNNABLE && !found_q) begin
					sum_nxt = sum_q + SW'(head.effective_share);
					if (sum_nxt > SW'(win_q)) begin
						hit = 1'b1;
					end
				end
			end
			OP_TICK: begin
				// boost decay of runnable slots, growth of sleeping ones
				if (head.run_state == RS_RUNNABLE && boost != '0) begin
					boost = boost - 16'd1;
					if (boost == '0) begin
						head_nxt.effective_share = {1'b0, head.base_share};
					end else begin
						head_nxt.effective_share = {head.base_share, 1'b0};
					end
				end
				if (head.run_state == RS_SLEEPING && boost != BOOST_MAX) begin
					boost = boost + 16'd1;
				end
				// wake timed sleepers whose time is up
				if (head.run_state == RS_SLEEPING && head.sleep_length != '0 &&
						elapsed >= head.sleep_length) begin
					head_nxt.run_state    = RS_RUNNABLE;
					head_nxt.sleep_length = '0;
					if (boost == '0) begin
						boost = (elapsed > 32'(BOOST_MAX)) ? BOOST_MAX : elapsed[15:0];
						head_nxt.effective_share = {head.base_share, 1'b0};
					end
				end
				head_nxt.boost_left = boost;
			end
			OP_SET: begin
				if (!found_q && head.pid == req_q.pid_in) begin
					hit = 1'b1;
					head_nxt.base_share = req_q.ticket_count;
					if (head.boost_left == '0) begin
						head_nxt.effective_share = {1'b0, req_q.ticket_count};
					end else begin
						head_nxt.effective_share = {req_q.ticket_count, 1'b0};
					end
				end
			end
			OP_LOAD: begin
				if ((IW + 6)'(req_q.slot_index) == cnt_ext) begin
					hit = 1'b1;
					head_nxt.run_state       = req_q.run_state_in;
					head_nxt.pid             = req_q.pid_in;
					head_nxt.base_share      = req_q.ticket_count;
					head_nxt.effective_share = {1'b0, req_q.ticket_count};
					head_nxt.boost_left      = '0;
					head_nxt.sleep_begin     = tick_q;
					head_nxt.sleep_length    = req_q.sleep_ticks;
				end
			end
			default: begin
			end
		endcase
	end

	// response of the finished command
	always_comb begin
		res = '0;
		if (zero_q) begin
			res.status = STAT_ZERO;
		end else if (req_q.opcode == OP_TICK) begin
			res.status = STAT_OK;
		end else if (found_q) begin
			res.status      = STAT_OK;
			res.winner_slot = hit_slot_q;
			res.winner_pid  = hit_pid_q;
		end else begin
			res.status = STAT_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			zero_q      <= 1'b0;
			tick_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output beat: loaded from the holding state, dropped once taken
			if (state_q == S_HOLD && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						zero_q  <= (req.opcode == OP_DRAW) && (req.draw_total == '0);
						cnt_q   <= '0;
						if (req.opcode == OP_TICK) begin
							tick_q <= tick_q + 32'd1;
						end
						if (req.opcode == OP_DRAW) begin
							if (req.draw_total == '0) begin
								state_q <= S_HOLD;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (cnt_q == IW'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_HOLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_HOLD: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			sum_q <= '0;
		end
		if (state_q == S_DIV && div_done) begin
			win_q <= div_rem;
		end
		if (shift) begin
			sum_q <= sum_nxt;
			if (hit) begin
				hit_slot_q <= cnt_slot;
				hit_pid_q  <= head_nxt.pid;
			end
		end
		if (state_q == S_HOLD && rsp_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the slot counter only runs during a scan
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_SCAN |-> cnt_q == '0)
		else $error("slot counter not at zero outside a scan");

	// an accepted request always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but block idle");

	// a response leaving the holding state is presented next cycle
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HOLD && rsp_free |=> rsp_valid)
		else $error("finished response not presented");

	// a zero ticket total never reaches the remainder unit
	a_zero_nodiv: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q && state_q != S_IDLE |-> state_q == S_HOLD)
		else $error("zero total draw entered the scan");

endmodule
